[sv/qcb_pkg.sv]
`timescale 1ns / 1ps

package qcb_pkg;

   localparam logic [1:0] KIND_PIN_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_BUS_WRITE  = 2'd1;
   localparam logic [1:0] KIND_BUS_READ   = 2'd2;
   localparam logic [1:0] KIND_TICK       = 2'd3;

   localparam logic [7:0] CMD_READ_NONE      = 8'h00;
   localparam logic [7:0] CMD_WRITE_POSITION = 8'h41;
   localparam logic [7:0] CMD_SET_MODE       = 8'h42;
   localparam logic [7:0] CMD_SET_INTERVAL   = 8'h43;
   localparam int         CMD_WRITE_BIT      = 6;

   localparam logic [1:0] PHASE_COMMAND = 2'd0;
   localparam logic [1:0] PHASE_LOW     = 2'd1;
   localparam logic [1:0] PHASE_HIGH    = 2'd2;

   localparam logic [15:0] MODE_LIVE    = 16'd0;
   localparam logic [15:0] MODE_LATCHED = 16'd1;

   localparam logic [3:0]  HISTORY_RESET  = 4'd12;
   localparam logic [15:0] INTERVAL_RESET = 16'd10;

   typedef struct packed {
      logic [1:0] kind;
      logic       pin_a;
      logic       pin_b;
      logic [7:0] bus_byte;
      logic       frame_restart;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic               change_pulse;
   } rsp_type;

   // quadrature step for {new b, new a, old b, old a}
   function automatic logic signed [2:0] step_delta(input logic [3:0] idx);
      logic signed [2:0] d;
      case (idx)
         4'd0:    d = 3'sd0;
         4'd1:    d = 3'sd1;
         4'd2:    d = -3'sd1;
         4'd3:    d = 3'sd2;
         4'd4:    d = -3'sd1;
         4'd5:    d = 3'sd0;
         4'd6:    d = -3'sd2;
         4'd7:    d = 3'sd1;
         4'd8:    d = 3'sd1;
         4'd9:    d = -3'sd2;
         4'd10:   d = 3'sd0;
         4'd11:   d = -3'sd1;
         4'd12:   d = 3'sd2;
         4'd13:   d = -3'sd1;
         4'd14:   d = 3'sd1;
         default: d = 3'sd0;
      endcase
      return d;
   endfunction

endpackage

[sv/qcb_core.sv]
`timescale 1ns / 1ps

module qcb_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  qcb_pkg::req_type req_data,
   output qcb_pkg::rsp_type rsp_data
);
   import qcb_pkg::*;

   logic [3:0]  history_ff,  history_in;
   logic [31:0] position_ff, position_in;
   logic [31:0] latched_ff,  latched_in;
   logic [15:0] mode_ff,     mode_in;
   logic [15:0] interval_ff, interval_in;
   logic [16:0] elapsed_ff,  elapsed_in;
   logic [1:0]  phase_ff,    phase_in;
   logic [7:0]  command_ff,  command_in;
   logic [7:0]  low_ff,      low_in;

   logic [3:0]        pin_idx;
   logic signed [2:0] pin_delta;
   logic [1:0]        phase_cur;
   logic [7:0]        command_cur;
   logic [15:0]       frame_value;
   logic [16:0]       elapsed_inc;

   always_comb begin
      history_in  = history_ff;
      position_in = position_ff;
      latched_in  = latched_ff;
      mode_in     = mode_ff;
      interval_in = interval_ff;
      elapsed_in  = elapsed_ff;
      phase_in    = phase_ff;
      command_in  = command_ff;
      low_in      = low_ff;
      rsp_data    = '0;

      pin_idx     = {req_data.pin_b, req_data.pin_a, history_ff[3:2]};
      pin_delta   = step_delta(pin_idx);
      phase_cur   = req_data.frame_restart ? PHASE_COMMAND : phase_ff;
      command_cur = (phase_cur == PHASE_COMMAND) ? req_data.bus_byte : command_ff;
      frame_value = {req_data.bus_byte, low_ff};
      elapsed_inc = elapsed_ff + 17'd1;

      case (req_data.kind)
         KIND_PIN_SAMPLE: begin
            history_in  = pin_idx;
            position_in = position_ff + {{29{pin_delta[2]}}, pin_delta};
         end
         KIND_BUS_WRITE: begin
            command_in = command_cur;
            if (!command_cur[CMD_WRITE_BIT]) begin
               // a zero command frame ends on its command byte
               if (command_cur == CMD_READ_NONE && phase_cur == PHASE_COMMAND) begin
                  phase_in = PHASE_COMMAND;
               end else begin
                  phase_in = (phase_cur >= PHASE_HIGH) ? PHASE_COMMAND : phase_cur + 2'd1;
               end
            end else begin
               if (phase_cur == PHASE_LOW) begin
                  low_in = req_data.bus_byte;
               end else if (phase_cur == PHASE_HIGH) begin
                  case (command_cur)
                     CMD_WRITE_POSITION: position_in = {{16{frame_value[15]}}, frame_value};
                     CMD_SET_MODE:       mode_in     = frame_value;
                     CMD_SET_INTERVAL:   interval_in = frame_value;
                     default: ;
                  endcase
               end
               phase_in = (phase_cur >= PHASE_HIGH) ? PHASE_COMMAND : phase_cur + 2'd1;
            end
         end
         KIND_BUS_READ: begin
            if (mode_ff == MODE_LIVE) begin
               rsp_data.read_value = position_ff[15:0];
            end else if (mode_ff == MODE_LATCHED) begin
               rsp_data.read_value = latched_ff[15:0];
            end
         end
         default: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc > {1'b0, interval_ff}) begin
               elapsed_in = '0;
               if (position_ff != latched_ff) begin
                  latched_in            = position_ff;
                  rsp_data.change_pulse = 1'b1;
                  if (mode_ff == MODE_LATCHED) begin
                     position_in = '0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff  <= HISTORY_RESET;
         position_ff <= '0;
         latched_ff  <= '0;
         mode_ff     <= MODE_LIVE;
         interval_ff <= INTERVAL_RESET;
         elapsed_ff  <= '0;
         phase_ff    <= PHASE_COMMAND;
         command_ff  <= '0;
         low_ff      <= '0;
      end else if (req_fire) begin
         history_ff  <= history_in;
         position_ff <= position_in;
         latched_ff  <= latched_in;
         mode_ff     <= mode_in;
         interval_ff <= interval_in;
         elapsed_ff  <= elapsed_in;
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         low_ff      <= low_in;
      end
   end

endmodule

[sv/qcb_out_buf.sv]
`timescale 1ns / 1ps

module qcb_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  qcb_pkg::rsp_type in_data,
   output logic             in_stall,
   output logic             rsp_valid,
   output qcb_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);
   import qcb_pkg::*;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    in_fire;
   logic    out_free;

   assign in_stall  = skid_valid_ff;
   assign in_fire   = in_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

[sv/quadrature_counter_bus_slave.sv]
`timescale 1ns / 1ps

// Quadrature encoder counter with a 3-byte framed register bus. One request is
// taken every clock while req_stall is low; its result is registered before it
// appears on rsp. Every request yields exactly one response: read data for
// bus reads, a change pulse for millisecond ticks, zero otherwise. A two-entry
// output buffer lets requests keep flowing while a response waits; req_stall
// rises only when both entries are held by a stalled response channel.

module quadrature_counter_bus_slave (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qcb_pkg::rsp_type rsp_data
);
   import qcb_pkg::*;

   logic    req_fire;
   rsp_type core_rsp;

   assign req_fire = req_valid && !req_stall;

   qcb_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .rsp_data (core_rsp)
   );

   qcb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (core_rsp),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
